// File: hw/rtl/fxlms_pkg.sv
// ----------------------------------------------------------------------------
// fxlms_pkg: shared types and constants of the filtered-x LMS adaptive FIR
// Sizes of the tap chain, arithmetic widths, handshake payloads and the
// control structs that run between the sequencer, the tap cells and the MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package fxlms_pkg;

    // Number of filter taps (2 to 256)
    localparam int TAPS    = 32;

    localparam int SMP_W   = 16;                    // Q1.15 samples
    localparam int WGT_W   = 32;                    // Q2.30 weights
    localparam int STEP_W  = 16;                    // Q0.16 step size
    localparam int CNT_W   = $clog2(TAPS + 1);      // rotation counter, 0..TAPS
    localparam int MUE_W   = STEP_W + 1 + SMP_W;    // mu * e, signed
    localparam int UPD_W   = MUE_W + SMP_W;         // mu * e * x', signed
    localparam int PROD_W  = WGT_W + SMP_W;         // w * x, signed
    localparam int ACC_W   = PROD_W + $clog2(TAPS); // dot product sum

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(328);

    // Input request payload
    typedef struct packed {
        logic signed [SMP_W-1:0] ref_sample;
        logic signed [SMP_W-1:0] filtered_ref_sample;
        logic signed [SMP_W-1:0] error_sample;
    } t_in_item;

    // Result payload
    typedef struct packed {
        logic signed [SMP_W-1:0] filter_out;
        logic                    clipped;
    } t_out_item;

    // Control of every tap cell
    typedef struct packed {
        logic shift_line;   // push a new sample pair into the tap lines
        logic rotate;       // move every cell one step around the ring
    } t_cell_ctl;

    // Control of the shared multiply-accumulate and update unit
    typedef struct packed {
        logic start;        // new request: latch mu*e, clear sum and clip flag
        logic rotate;       // capture the tail cell this cycle
        logic tap_vld;      // the tail cell holds a real tap
    } t_mac_ctl;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/fxlms_adaptive_fir.sv
// ----------------------------------------------------------------------------
// fxlms_adaptive_fir: filtered-x LMS adaptive FIR filter, TAPS taps
// The block takes no new request until the last one is done; the ring of tap
// cells rotates once, TAPS+1 steps, through the single shared MAC unit.
// A finished result waits in place while the output register is still full.
// Reset clears all samples and weights at once and sets step_size to 328.
// ----------------------------------------------------------------------------
`default_nettype none

module fxlms_adaptive_fir (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fxlms_pkg::STEP_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire fxlms_pkg::t_in_item           i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output fxlms_pkg::t_out_item               o_out_data
);
    import fxlms_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_vld;
    t_out_item            r_out_data;

    logic                 w_accept;
    logic                 w_load_out;
    logic                 w_rot_done;
    t_cell_ctl            w_cell_ctl;
    t_mac_ctl             w_mac_ctl;

    logic signed [SMP_W-1:0] w_cx [TAPS];
    logic signed [SMP_W-1:0] w_cf [TAPS];
    logic signed [WGT_W-1:0] w_cw [TAPS];
    logic signed [SMP_W-1:0] w_x_head;
    logic signed [SMP_W-1:0] w_f_head;
    logic signed [WGT_W-1:0] w_w_head;
    logic signed [SMP_W-1:0] w_x_in0;
    logic signed [SMP_W-1:0] w_f_in0;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_wclip;

    logic signed [ACC_W:0]   w_ysum;
    logic                    w_yovf;
    t_out_item               w_result;

    // Hold the step size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    assign w_rot_done = (r_cnt == CNT_W'(TAPS));

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_rot_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_ROT:   o_in_ready = 1'b0;
            S_FIN:   w_load_out = !r_out_vld || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Drive the chain and the MAC
    always_comb begin
        w_cell_ctl.shift_line = w_accept;
        w_cell_ctl.rotate     = (r_state == S_ROT);
        w_mac_ctl.start       = w_accept;
        w_mac_ctl.rotate      = (r_state == S_ROT);
        w_mac_ctl.tap_vld     = !w_rot_done;
    end

    // First cell takes the new samples on a shift, the MAC output on a rotation
    assign w_x_in0 = w_accept ? i_in_data.ref_sample          : w_x_head;
    assign w_f_in0 = w_accept ? i_in_data.filtered_ref_sample : w_f_head;

    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++) begin : g_tap
            if (gi == 0) begin : g_first
                fxlms_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_cell_ctl),
                    .i_x_prev (w_x_in0),
                    .i_f_prev (w_f_in0),
                    .i_w_prev (w_w_head),
                    .o_x      (w_cx[gi]),
                    .o_f      (w_cf[gi]),
                    .o_w      (w_cw[gi])
                );
            end else begin : g_next
                fxlms_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_cell_ctl),
                    .i_x_prev (w_cx[gi-1]),
                    .i_f_prev (w_cf[gi-1]),
                    .i_w_prev (w_cw[gi-1]),
                    .o_x      (w_cx[gi]),
                    .o_f      (w_cf[gi]),
                    .o_w      (w_cw[gi])
                );
            end
        end
    endgenerate

    fxlms_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_step   (r_step),
        .i_err    (i_in_data.error_sample),
        .i_x_tail (w_cx[TAPS-1]),
        .i_f_tail (w_cf[TAPS-1]),
        .i_w_tail (w_cw[TAPS-1]),
        .o_x_head (w_x_head),
        .o_f_head (w_f_head),
        .o_w_head (w_w_head),
        .o_acc    (w_acc),
        .o_clip   (w_wclip)
    );

    // Round the sum to Q1.15 and saturate
    always_comb begin
        w_ysum = {w_acc[ACC_W-1], w_acc} + (ACC_W+1)'(1 << 29);
        if (w_ysum[ACC_W]) begin
            w_yovf = !(&w_ysum[ACC_W:45]);
        end else begin
            w_yovf = |w_ysum[ACC_W:45];
        end
        if (w_yovf) begin
            w_result.filter_out = w_ysum[ACC_W] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            w_result.filter_out = w_ysum[45:30];
        end
        w_result.clipped = w_yovf || w_wclip;
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    a_accept_starts_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ROT) && (r_cnt == '0))
        else $error("accepted request did not start the ring rotation");

    a_ring_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && w_rot_done) |=> (r_state == S_FIN))
        else $error("ring rotation did not end after TAPS+1 steps");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_vld && !i_out_ready) |=> (r_state == S_FIN))
        else $error("result left while the output register was still full");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/fxlms_cell.sv
// ----------------------------------------------------------------------------
// fxlms_cell: one tap of the filter
// Holds a reference sample, a filtered-reference sample and a weight, and
// hands them to the next cell when the line shifts or the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module fxlms_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fxlms_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [fxlms_pkg::SMP_W-1:0]  i_x_prev,
    input  wire logic signed [fxlms_pkg::SMP_W-1:0]  i_f_prev,
    input  wire logic signed [fxlms_pkg::WGT_W-1:0]  i_w_prev,
    output logic signed      [fxlms_pkg::SMP_W-1:0]  o_x,
    output logic signed      [fxlms_pkg::SMP_W-1:0]  o_f,
    output logic signed      [fxlms_pkg::WGT_W-1:0]  o_w
);
    import fxlms_pkg::*;

    logic signed [SMP_W-1:0] r_x;
    logic signed [SMP_W-1:0] r_f;
    logic signed [WGT_W-1:0] r_w;

    // Advance samples on a line shift or a rotation; weights only rotate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_f <= '0;
            r_w <= '0;
        end else begin
            if (i_ctl.shift_line || i_ctl.rotate) begin
                r_x <= i_x_prev;
                r_f <= i_f_prev;
            end
            if (i_ctl.rotate) begin
                r_w <= i_w_prev;
            end
        end
    end

    assign o_x = r_x;
    assign o_f = r_f;
    assign o_w = r_w;

endmodule

`default_nettype wire

// File: hw/rtl/fxlms_mac.sv
// ----------------------------------------------------------------------------
// fxlms_mac: shared multiply-accumulate and weight update unit
// Sits in the ring between the last cell and the first: forms w*x into the
// dot product sum and returns each weight updated by mu*e*x', saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module fxlms_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fxlms_pkg::t_mac_ctl                 i_ctl,
    input  wire logic        [fxlms_pkg::STEP_W-1:0] i_step,
    input  wire logic signed [fxlms_pkg::SMP_W-1:0]  i_err,
    input  wire logic signed [fxlms_pkg::SMP_W-1:0]  i_x_tail,
    input  wire logic signed [fxlms_pkg::SMP_W-1:0]  i_f_tail,
    input  wire logic signed [fxlms_pkg::WGT_W-1:0]  i_w_tail,
    output logic signed      [fxlms_pkg::SMP_W-1:0]  o_x_head,
    output logic signed      [fxlms_pkg::SMP_W-1:0]  o_f_head,
    output logic signed      [fxlms_pkg::WGT_W-1:0]  o_w_head,
    output logic signed      [fxlms_pkg::ACC_W-1:0]  o_acc,
    output logic                                     o_clip
);
    import fxlms_pkg::*;

    logic signed [MUE_W-1:0]  r_mue;
    logic signed [SMP_W-1:0]  r_xa;
    logic signed [SMP_W-1:0]  r_fa;
    logic signed [WGT_W-1:0]  r_wa;
    logic signed [PROD_W-1:0] r_pw;
    logic signed [UPD_W-1:0]  r_pd;
    logic                     r_a_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_clip;

    logic signed [UPD_W-1:0]  w_rnd;
    logic signed [MUE_W-1:0]  w_delta;
    logic signed [WGT_W+1:0]  w_diff;
    logic                     w_sat_hi;
    logic                     w_sat_lo;

    // Latch mu*e once per request
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mue <= $signed({1'b0, i_step}) * i_err;
        end
    end

    // Capture the tail cell and both products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xa    <= '0;
            r_fa    <= '0;
            r_wa    <= '0;
            r_pw    <= '0;
            r_pd    <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.rotate && i_ctl.tap_vld;
            if (i_ctl.rotate) begin
                r_xa <= i_x_tail;
                r_fa <= i_f_tail;
                r_wa <= i_w_tail;
                r_pw <= i_w_tail * i_x_tail;
                r_pd <= r_mue * i_f_tail;
            end
        end
    end

    // Round the update to Q2.30, subtract and saturate
    always_comb begin
        w_rnd    = r_pd + UPD_W'(1 << 15);
        w_delta  = w_rnd[UPD_W-1:16];
        w_diff   = {{2{r_wa[WGT_W-1]}}, r_wa} - (WGT_W+2)'(w_delta);
        w_sat_hi = !w_diff[WGT_W+1] && (w_diff[WGT_W:WGT_W-1] != 2'b00);
        w_sat_lo = w_diff[WGT_W+1] && (w_diff[WGT_W:WGT_W-1] != 2'b11);
        if (w_sat_hi) begin
            o_w_head = {1'b0, {(WGT_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            o_w_head = {1'b1, {(WGT_W-1){1'b0}}};
        end else begin
            o_w_head = w_diff[WGT_W-1:0];
        end
    end

    assign o_x_head = r_xa;
    assign o_f_head = r_fa;

    // Accumulate the dot product and collect weight saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (i_ctl.start) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (r_a_vld) begin
            r_acc  <= r_acc + ACC_W'(r_pw);
            r_clip <= r_clip || w_sat_hi || w_sat_lo;
        end
    end

    assign o_acc  = r_acc;
    assign o_clip = r_clip;

endmodule

`default_nettype wire
